@@ rtl/core/pcir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair collision resolver package
// Shared payload types, widths, constants and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package pcir_pkg;

    localparam int unsigned CFG_W    = 17;
    localparam int unsigned NORM_QW  = 31;  // quotient bits of a normal component
    localparam int unsigned DIST_W   = 32;  // bits of the centre distance
    localparam int unsigned SHARE_QW = 24;  // quotient bits of a mass share

    localparam logic [CFG_W-1:0] RESTITUTION_RESET = 17'd52429;
    localparam logic [15:0]      PUSH_FRAC         = 16'd52429;  // 0.8 in Q0.16

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic [30:0]        first_radius;
        logic [30:0]        first_mass;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic [30:0]        second_radius;
        logic [30:0]        second_mass;
    } t_pair_in;

    typedef struct packed {
        logic               contact;
        logic               resolved;
        logic signed [31:0] new_first_pos_x;
        logic signed [31:0] new_first_pos_y;
        logic signed [31:0] new_first_vel_x;
        logic signed [31:0] new_first_vel_y;
        logic signed [31:0] new_second_pos_x;
        logic signed [31:0] new_second_pos_y;
        logic signed [31:0] new_second_vel_x;
        logic signed [31:0] new_second_vel_y;
    } t_pair_out;

    // Clamp a widened sum to the signed 32-bit Q16.16 range.
    function automatic logic signed [31:0] sat_q16(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pcir_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one root bit per register stage.
// ----------------------------------------------------------------------------
module pcir_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);
    localparam int unsigned STEPS = 32;
    localparam int unsigned REM_W = 34;

    logic [63:0]      r_x    [STEPS];
    logic [REM_W-1:0] r_rem  [STEPS];
    logic [31:0]      r_root [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [63:0]      x_in;
        logic [REM_W-1:0] rem_in;
        logic [31:0]      root_in;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic             ge;

        if (g == 0) begin : g_first
            assign x_in    = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign x_in    = r_x[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // Bring down the next pair of bits and try appending a one to the root.
        assign t     = {rem_in, x_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            r_x[g]    <= {x_in[61:0], 2'b00};
            r_rem[g]  <= ge ? REM_W'(t - trial) : t[REM_W-1:0];
            r_root[g] <= {root_in[30:0], ge};
        end
    end

    assign o_root = r_root[STEPS-1];

endmodule

@@ rtl/core/pcir_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the divisor travels along and is
// available at the output, aligned with the quotient.
// ----------------------------------------------------------------------------
module pcir_div #(
    parameter int unsigned QW = pcir_pkg::NORM_QW,
    parameter int unsigned DW = pcir_pkg::DIST_W
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,   // upper dividend bits, below the divisor
    input  logic [QW-1:0] i_low,   // lower dividend bits, shifted in msb first
    input  logic [DW-1:0] i_div,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_div
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_dsr [QW];

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] dsr_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   t;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_in = i_rem;
            assign dsr_in = i_div;
            assign low_in = i_low;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = r_rem[g-1];
            assign dsr_in = r_dsr[g-1];
            assign low_in = r_low[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign t  = {rem_in, low_in[QW-1]};
        assign ge = (t >= {1'b0, dsr_in});

        always_ff @(posedge i_clk) begin
            r_rem[g] <= ge ? DW'(t - {1'b0, dsr_in}) : t[DW-1:0];
            r_low[g] <= {low_in[QW-2:0], 1'b0};
            r_quo[g] <= {quo_in[QW-2:0], ge};
            r_dsr[g] <= dsr_in;
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_div = r_dsr[QW-1];

endmodule

@@ rtl/core/pair_collision_impulse_resolver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair collision impulse resolver
// Contact test, impulse response and overlap push for two circular particles.
// ----------------------------------------------------------------------------
// Usage:
// A candidate pair is presented on i_pair and transferred at a rising edge
// where start is high and busy is low. Every transfer produces exactly one
// result on o_result, marked by o_strobe for a single cycle. The result has
// no back-pressure: the receiver must take it in the cycle it is shown.
// Throughput is one pair per clock while busy is low. The pipeline is fully
// unrolled: three entry stages, a 32-stage square root for the centre
// distance, followed by 31-stage dividers for the normal components (the
// mass shares are divided alongside), then seven stages of multiply, sum
// and saturate. The root and divider chains set the latency; only busy
// limits the issue rate. Restitution is written through i_cfg_we /
// i_cfg_wdata and must only change while no pair is in flight. Reset clears
// every valid bit, restores the restitution to 0.8 and holds busy high until
// the first edge after reset is released.
// ----------------------------------------------------------------------------
module pair_collision_impulse_resolver_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pcir_pkg::t_pair_in            i_pair,
    output logic                          o_strobe,
    output pcir_pkg::t_pair_out           o_result,
    input  logic                          i_cfg_we,
    input  logic [pcir_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import pcir_pkg::*;

    localparam int unsigned DLY     = 63;  // root plus normal divider stages
    localparam int unsigned ROOT_AT = 31;  // delay tap aligned with the root
    localparam int unsigned SHR_AT  = DLY - 1 - SHARE_QW;

    // Side data that rides along with each pair through the long stages.
    typedef struct packed {
        t_pair_in           pair;
        logic [31:0]        ux;
        logic [31:0]        uy;
        logic               sx;
        logic               sy;
        logic [31:0]        rs;
        logic [30:0]        m1;
        logic [30:0]        m2;
        logic [31:0]        msum;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               contact;
        logic               nz;
    } t_side;

    logic               r_busy;
    logic [CFG_W-1:0]   r_restitution;
    logic               accept;

    // Stage 1: differences and sums.
    logic               r_av;
    t_side              r_a;
    t_side              n_a;
    logic signed [32:0] dx;
    logic signed [32:0] dy;

    // Stage 2: squares.
    logic               r_bv;
    t_side              r_b;
    logic [63:0]        r_b_sqx;
    logic [63:0]        r_b_sqy;
    logic [63:0]        r_b_rsq;

    // Stage 3: squared distance and contact.
    logic               r_cv;
    t_side              r_c;
    t_side              n_c;
    logic [63:0]        r_c_dsq;
    logic [64:0]        dsq_sum;

    // Long stages: root and dividers, side data delayed alongside.
    logic               r_dv  [DLY];
    t_side              r_dly [DLY];
    logic [31:0]        root;
    logic [NORM_QW-1:0] qx_w;
    logic [NORM_QW-1:0] qy_w;
    logic [DIST_W-1:0]  dist_w;
    logic [DIST_W-1:0]  dist_unused;
    logic [SHARE_QW-1:0] s1_w;
    logic [SHARE_QW-1:0] s2_w;
    logic [DIST_W-1:0]  msum_x1;
    logic [DIST_W-1:0]  msum_x2;

    // Stage E1: normal products and overlap.
    logic               r_e1v;
    t_side              r_e1;
    logic signed [64:0] r_e1_px;
    logic signed [64:0] r_e1_py;
    logic signed [32:0] r_e1_ovl;
    logic [NORM_QW-1:0] r_e1_qx;
    logic [NORM_QW-1:0] r_e1_qy;
    logic [SHARE_QW-1:0] r_e1_s1;
    logic [SHARE_QW-1:0] r_e1_s2;
    logic signed [31:0] nxs;
    logic signed [31:0] nys;

    // Stage E2: normal speed and scaled overlap.
    logic               r_e2v;
    t_side              r_e2;
    logic signed [63:0] r_e2_vn;
    logic [31:0]        r_e2_o8;
    logic [NORM_QW-1:0] r_e2_qx;
    logic [NORM_QW-1:0] r_e2_qy;
    logic [SHARE_QW-1:0] r_e2_s1;
    logic [SHARE_QW-1:0] r_e2_s2;
    logic [47:0]        oprod;

    // Stage E3: speed magnitude, push magnitudes.
    logic               r_e3v;
    t_side              r_e3;
    logic               r_e3_res;
    logic [32:0]        r_e3_mag;
    logic [31:0]        r_e3_b1;
    logic [31:0]        r_e3_b2;
    logic [NORM_QW-1:0] r_e3_qx;
    logic [NORM_QW-1:0] r_e3_qy;
    logic [SHARE_QW-1:0] r_e3_s1;
    logic [SHARE_QW-1:0] r_e3_s2;
    logic [63:0]        vneg;
    logic [55:0]        bprod1;
    logic [55:0]        bprod2;

    // Stage E4: impulse magnitude.
    logic               r_e4v;
    t_side              r_e4;
    logic               r_e4_res;
    logic [34:0]        r_e4_k;
    logic [31:0]        r_e4_b1;
    logic [31:0]        r_e4_b2;
    logic [NORM_QW-1:0] r_e4_qx;
    logic [NORM_QW-1:0] r_e4_qy;
    logic [SHARE_QW-1:0] r_e4_s1;
    logic [SHARE_QW-1:0] r_e4_s2;
    logic [17:0]        rfac;
    logic [50:0]        kprod;

    // Stage E5: per-particle velocity change magnitudes.
    logic               r_e5v;
    t_side              r_e5;
    logic               r_e5_res;
    logic [34:0]        r_e5_a1;
    logic [34:0]        r_e5_a2;
    logic [31:0]        r_e5_b1;
    logic [31:0]        r_e5_b2;
    logic [NORM_QW-1:0] r_e5_qx;
    logic [NORM_QW-1:0] r_e5_qy;
    logic [58:0]        aprod1;
    logic [58:0]        aprod2;

    // Stage E6: per-axis deltas.
    logic               r_e6v;
    t_side              r_e6;
    logic               r_e6_res;
    logic [35:0]        r_e6_dv [4];
    logic [35:0]        r_e6_dp [4];
    logic [65:0]        vprod   [4];
    logic [62:0]        pprod   [4];

    t_pair_out          n_out;
    logic               r_strobe;
    t_pair_out          r_out;

    // Move a base value by a magnitude, subtracting when neg is set.
    function automatic logic signed [31:0] f_nudge(input logic signed [31:0] base,
                                                    input logic [35:0] mag,
                                                    input logic neg);
        logic signed [36:0] m;
        logic signed [36:0] s;
        m = $signed({1'b0, mag});
        s = 37'(base) + (neg ? -m : m);
        return sat_q16(s);
    endfunction

    assign accept = start && !busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_restitution <= RESTITUTION_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_restitution <= i_cfg_wdata;
            end
        end
    end

    // ---------------- Stage 1 ----------------
    always_comb begin
        n_a      = '0;
        n_a.pair = i_pair;
        dx = 33'(i_pair.first_pos_x) - 33'(i_pair.second_pos_x);
        dy = 33'(i_pair.first_pos_y) - 33'(i_pair.second_pos_y);
        n_a.sx = dx[32];
        n_a.sy = dy[32];
        n_a.ux = dx[32] ? 32'(-dx) : dx[31:0];
        n_a.uy = dy[32] ? 32'(-dy) : dy[31:0];
        n_a.rs = {1'b0, i_pair.first_radius} + {1'b0, i_pair.second_radius};
        // A zero mass counts as the smallest representable mass.
        n_a.m1 = (i_pair.first_mass == '0) ? 31'd1 : i_pair.first_mass;
        n_a.m2 = (i_pair.second_mass == '0) ? 31'd1 : i_pair.second_mass;
        n_a.msum = {1'b0, n_a.m1} + {1'b0, n_a.m2};
        n_a.rvx = 33'(i_pair.first_vel_x) - 33'(i_pair.second_vel_x);
        n_a.rvy = 33'(i_pair.first_vel_y) - 33'(i_pair.second_vel_y);
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= r_a;
        r_b_sqx <= r_a.ux * r_a.ux;
        r_b_sqy <= r_a.uy * r_a.uy;
        r_b_rsq <= r_a.rs * r_a.rs;
    end

    // ---------------- Stage 3 ----------------
    // A sum past 64 bits can never be a contact.
    assign dsq_sum = {1'b0, r_b_sqx} + {1'b0, r_b_sqy};

    always_comb begin
        n_c         = r_b;
        n_c.contact = !dsq_sum[64] && (dsq_sum[63:0] <= r_b_rsq);
        n_c.nz      = (dsq_sum != '0);
    end

    always_ff @(posedge i_clk) begin
        r_c     <= n_c;
        r_c_dsq <= dsq_sum[63:0];
    end

    // ---------------- Long stages ----------------
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_c;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    pcir_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r_c_dsq),
        .o_root (root)
    );

    // Where dsq fits in 64 bits, the normal components are at most one, so
    // the leading dividend bits (component over two) sit below a nonzero root.
    pcir_div #(.QW(NORM_QW), .DW(DIST_W)) u_div_nx (
        .i_clk (i_clk),
        .i_rem ({1'b0, r_dly[ROOT_AT].ux[31:1]}),
        .i_low ({r_dly[ROOT_AT].ux[0], {(NORM_QW-1){1'b0}}}),
        .i_div (root),
        .o_quo (qx_w),
        .o_div (dist_w)
    );

    pcir_div #(.QW(NORM_QW), .DW(DIST_W)) u_div_ny (
        .i_clk (i_clk),
        .i_rem ({1'b0, r_dly[ROOT_AT].uy[31:1]}),
        .i_low ({r_dly[ROOT_AT].uy[0], {(NORM_QW-1){1'b0}}}),
        .i_div (root),
        .o_quo (qy_w),
        .o_div (dist_unused)
    );

    pcir_div #(.QW(SHARE_QW), .DW(DIST_W)) u_div_s1 (
        .i_clk (i_clk),
        .i_rem ({1'b0, r_dly[SHR_AT].m2}),
        .i_low ('0),
        .i_div (r_dly[SHR_AT].msum),
        .o_quo (s1_w),
        .o_div (msum_x1)
    );

    pcir_div #(.QW(SHARE_QW), .DW(DIST_W)) u_div_s2 (
        .i_clk (i_clk),
        .i_rem ({1'b0, r_dly[SHR_AT].m1}),
        .i_low ('0),
        .i_div (r_dly[SHR_AT].msum),
        .o_quo (s2_w),
        .o_div (msum_x2)
    );

    // ---------------- Stage E1 ----------------
    assign nxs = r_dly[DLY-1].sx ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
    assign nys = r_dly[DLY-1].sy ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});

    always_ff @(posedge i_clk) begin
        r_e1     <= r_dly[DLY-1];
        r_e1_px  <= 65'(r_dly[DLY-1].rvx) * 65'(nxs);
        r_e1_py  <= 65'(r_dly[DLY-1].rvy) * 65'(nys);
        r_e1_ovl <= $signed({1'b0, r_dly[DLY-1].rs}) - $signed({1'b0, dist_w});
        r_e1_qx  <= qx_w;
        r_e1_qy  <= qy_w;
        r_e1_s1  <= s1_w;
        r_e1_s2  <= s2_w;
    end

    // ---------------- Stage E2 ----------------
    assign oprod = r_e1_ovl[31:0] * PUSH_FRAC;

    always_ff @(posedge i_clk) begin
        r_e2    <= r_e1;
        r_e2_vn <= 64'(r_e1_px + r_e1_py);
        // Without a positive overlap the positions are left alone.
        r_e2_o8 <= (!r_e1_ovl[32] && r_e1_ovl != '0) ? oprod[47:16] : '0;
        r_e2_qx <= r_e1_qx;
        r_e2_qy <= r_e1_qy;
        r_e2_s1 <= r_e1_s1;
        r_e2_s2 <= r_e1_s2;
    end

    // ---------------- Stage E3 ----------------
    assign vneg   = 64'(-r_e2_vn);
    assign bprod1 = r_e2_o8 * r_e2_s1;
    assign bprod2 = r_e2_o8 * r_e2_s2;

    always_ff @(posedge i_clk) begin
        r_e3     <= r_e2;
        // A pair already moving apart along the normal is left untouched.
        r_e3_res <= r_e2.contact && r_e2.nz && (r_e2_vn[63] || r_e2_vn == '0);
        r_e3_mag <= vneg[62:30];
        r_e3_b1  <= bprod1[55:24];
        r_e3_b2  <= bprod2[55:24];
        r_e3_qx  <= r_e2_qx;
        r_e3_qy  <= r_e2_qy;
        r_e3_s1  <= r_e2_s1;
        r_e3_s2  <= r_e2_s2;
    end

    // ---------------- Stage E4 ----------------
    assign rfac  = 18'h10000 + {1'b0, r_restitution};
    assign kprod = r_e3_mag * rfac;

    always_ff @(posedge i_clk) begin
        r_e4     <= r_e3;
        r_e4_res <= r_e3_res;
        r_e4_k   <= kprod[50:16];
        r_e4_b1  <= r_e3_b1;
        r_e4_b2  <= r_e3_b2;
        r_e4_qx  <= r_e3_qx;
        r_e4_qy  <= r_e3_qy;
        r_e4_s1  <= r_e3_s1;
        r_e4_s2  <= r_e3_s2;
    end

    // ---------------- Stage E5 ----------------
    assign aprod1 = r_e4_k * r_e4_s1;
    assign aprod2 = r_e4_k * r_e4_s2;

    always_ff @(posedge i_clk) begin
        r_e5     <= r_e4;
        r_e5_res <= r_e4_res;
        r_e5_a1  <= aprod1[58:24];
        r_e5_a2  <= aprod2[58:24];
        r_e5_b1  <= r_e4_b1;
        r_e5_b2  <= r_e4_b2;
        r_e5_qx  <= r_e4_qx;
        r_e5_qy  <= r_e4_qy;
    end

    // ---------------- Stage E6 ----------------
    // Order of the four lanes: first x, first y, second x, second y.
    assign vprod[0] = r_e5_a1 * r_e5_qx;
    assign vprod[1] = r_e5_a1 * r_e5_qy;
    assign vprod[2] = r_e5_a2 * r_e5_qx;
    assign vprod[3] = r_e5_a2 * r_e5_qy;
    assign pprod[0] = r_e5_b1 * r_e5_qx;
    assign pprod[1] = r_e5_b1 * r_e5_qy;
    assign pprod[2] = r_e5_b2 * r_e5_qx;
    assign pprod[3] = r_e5_b2 * r_e5_qy;

    always_ff @(posedge i_clk) begin
        r_e6     <= r_e5;
        r_e6_res <= r_e5_res;
        for (int i = 0; i < 4; i++) begin
            r_e6_dv[i] <= vprod[i][65:30];
            r_e6_dp[i] <= {3'b000, pprod[i][62:30]};
        end
    end

    // ---------------- Stage E7: apply, saturate, select ----------------
    always_comb begin
        n_out                  = '0;
        n_out.contact          = r_e6.contact;
        n_out.resolved         = r_e6_res;
        n_out.new_first_pos_x  = r_e6.pair.first_pos_x;
        n_out.new_first_pos_y  = r_e6.pair.first_pos_y;
        n_out.new_first_vel_x  = r_e6.pair.first_vel_x;
        n_out.new_first_vel_y  = r_e6.pair.first_vel_y;
        n_out.new_second_pos_x = r_e6.pair.second_pos_x;
        n_out.new_second_pos_y = r_e6.pair.second_pos_y;
        n_out.new_second_vel_x = r_e6.pair.second_vel_x;
        n_out.new_second_vel_y = r_e6.pair.second_vel_y;
        if (r_e6_res) begin
            // The first particle moves with the normal, the second against it.
            n_out.new_first_vel_x  = f_nudge(r_e6.pair.first_vel_x, r_e6_dv[0], r_e6.sx);
            n_out.new_first_vel_y  = f_nudge(r_e6.pair.first_vel_y, r_e6_dv[1], r_e6.sy);
            n_out.new_second_vel_x = f_nudge(r_e6.pair.second_vel_x, r_e6_dv[2], !r_e6.sx);
            n_out.new_second_vel_y = f_nudge(r_e6.pair.second_vel_y, r_e6_dv[3], !r_e6.sy);
            n_out.new_first_pos_x  = f_nudge(r_e6.pair.first_pos_x, r_e6_dp[0], r_e6.sx);
            n_out.new_first_pos_y  = f_nudge(r_e6.pair.first_pos_y, r_e6_dp[1], r_e6.sy);
            n_out.new_second_pos_x = f_nudge(r_e6.pair.second_pos_x, r_e6_dp[2], !r_e6.sx);
            n_out.new_second_pos_y = f_nudge(r_e6.pair.second_pos_y, r_e6_dp[3], !r_e6.sy);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ---------------- Valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av     <= 1'b0;
            r_bv     <= 1'b0;
            r_cv     <= 1'b0;
            r_e1v    <= 1'b0;
            r_e2v    <= 1'b0;
            r_e3v    <= 1'b0;
            r_e4v    <= 1'b0;
            r_e5v    <= 1'b0;
            r_e6v    <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else begin
            r_av    <= accept;
            r_bv    <= r_av;
            r_cv    <= r_bv;
            r_dv[0] <= r_cv;
            for (int i = 1; i < DLY; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_e1v    <= r_dv[DLY-1];
            r_e2v    <= r_e1v;
            r_e3v    <= r_e2v;
            r_e4v    <= r_e3v;
            r_e5v    <= r_e4v;
            r_e6v    <= r_e5v;
            r_strobe <= r_e6v;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // ---------------- Assertions ----------------
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe)
        else $error("pipeline not idle after reset");

    a_resolved_needs_contact : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.resolved |-> o_result.contact)
        else $error("resolved result without contact");

    a_normal_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e1v && r_e1.contact && r_e1.nz |->
            r_e1_qx <= 31'h40000000 && r_e1_qy <= 31'h40000000)
        else $error("normal component above one");

    // The divisor copies leaving the dividers must line up with the side data.
    a_divider_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[DLY-1] |->
            dist_unused == dist_w && msum_x1 == r_dly[DLY-1].msum &&
            msum_x2 == r_dly[DLY-1].msum)
        else $error("divider outputs out of step with the pair");

    a_pass_through : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e6v && !r_e6_res |=>
            o_result.new_first_vel_x == $past(r_e6.pair.first_vel_x) &&
            o_result.new_second_pos_y == $past(r_e6.pair.second_pos_y))
        else $error("unresolved pair was modified");

endmodule

@@ tb/tb_pair_collision_impulse_resolver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair collision impulse resolver testbench
// Sends directed and random particle pairs, predicts each collision response
// in a bit-exact Q16.16 predictor and checks every result field by field,
// under several restitution settings and several sender gap patterns.
// ----------------------------------------------------------------------------
module tb_pair_collision_impulse_resolver_top;
    import pcir_pkg::*;

    localparam int PIPE_LATENCY = 73;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    t_pair_in          pair;
    logic              strobe;
    t_pair_out         result;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    // Predictor copy of the restitution register.
    logic [CFG_W-1:0]  restitution_now;
    t_pair_out         pending_responses[$];
    int                mismatch_count;
    int                gap_percent;

    pair_collision_impulse_resolver_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_pair      (pair),
        .o_strobe    (strobe),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor. All widths follow the block's fixed-point description; the
    // normal speed is kept in 66 bits so the dot product can never wrap.
    // ------------------------------------------------------------------------
    function automatic longint clamp_q16(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] x);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] b;
        rem = x;
        root = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // base +/- mag * n / 2^30, minus when away is set, then saturated.
    function automatic longint shift_along(input longint base, input bit [63:0] mag,
                                           input longint n, input bit away);
        bit [63:0] nm;
        longint    d;
        nm = (n < 0) ? 64'(-n) : 64'(n);
        d = longint'((mag >> 30) * nm + (((mag & 64'h3FFFFFFF) * nm) >> 30));
        if ((n < 0) != away) d = -d;
        return clamp_q16(base + d);
    endfunction

    function automatic t_pair_out resolve_pair(input t_pair_in p, input logic [16:0] rest);
        t_pair_out         o;
        longint            x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy, nx, ny, overlap;
        bit [63:0]         m1, m2, ux, uy, sqx, sqy, rs, dsq, cdist, msum, s1, s2;
        bit [63:0]         mag, k, a1, a2, o8, b1, b2;
        logic signed [65:0] rvx, rvy, nxw, nyw, vn;
        bit                touch;
        bit                fixed;
        x1 = longint'(p.first_pos_x);   y1 = longint'(p.first_pos_y);
        vx1 = longint'(p.first_vel_x);  vy1 = longint'(p.first_vel_y);
        x2 = longint'(p.second_pos_x);  y2 = longint'(p.second_pos_y);
        vx2 = longint'(p.second_vel_x); vy2 = longint'(p.second_vel_y);
        m1 = (p.first_mass == 0) ? 64'd1 : 64'(p.first_mass);
        m2 = (p.second_mass == 0) ? 64'd1 : 64'(p.second_mass);
        touch = 1'b0;
        fixed = 1'b0;
        dsq = 0;
        dx = x1 - x2;
        dy = y1 - y2;
        ux = (dx < 0) ? 64'(-dx) : 64'(dx);
        uy = (dy < 0) ? 64'(-dy) : 64'(dy);
        sqx = ux * ux;
        sqy = uy * uy;
        rs = 64'(p.first_radius) + 64'(p.second_radius);
        // A squared distance beyond 64 bits is simply no contact.
        if (sqx <= ~sqy) begin
            dsq = sqx + sqy;
            touch = (dsq <= rs * rs);
        end
        if (touch && dsq != 0) begin
            cdist = int_sqrt(dsq);
            nx = longint'((ux << 30) / cdist);
            ny = longint'((uy << 30) / cdist);
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
            rvx = 66'(vx1) - 66'(vx2);
            rvy = 66'(vy1) - 66'(vy2);
            nxw = 66'(nx);
            nyw = 66'(ny);
            vn = rvx * nxw + rvy * nyw;
            // Separating pairs are left alone.
            if (vn <= 0) begin
                msum = m1 + m2;
                s1 = (m2 << 24) / msum;
                s2 = (m1 << 24) / msum;
                mag = 64'((-vn) >>> 30);
                k = (mag * (64'd65536 + 64'(rest))) >> 16;
                a1 = (k * s1) >> 24;
                a2 = (k * s2) >> 24;
                overlap = longint'(rs) - longint'(cdist);
                fixed = 1'b1;
                vx1 = shift_along(vx1, a1, nx, 1'b0);
                vy1 = shift_along(vy1, a1, ny, 1'b0);
                vx2 = shift_along(vx2, a2, nx, 1'b1);
                vy2 = shift_along(vy2, a2, ny, 1'b1);
                if (overlap > 0) begin
                    o8 = (64'(overlap) * 64'(PUSH_FRAC)) >> 16;
                    b1 = (o8 * s1) >> 24;
                    b2 = (o8 * s2) >> 24;
                    x1 = shift_along(x1, b1, nx, 1'b0);
                    y1 = shift_along(y1, b1, ny, 1'b0);
                    x2 = shift_along(x2, b2, nx, 1'b1);
                    y2 = shift_along(y2, b2, ny, 1'b1);
                end
            end
        end
        o.contact = touch;
        o.resolved = fixed;
        o.new_first_pos_x = x1[31:0];   o.new_first_pos_y = y1[31:0];
        o.new_first_vel_x = vx1[31:0];  o.new_first_vel_y = vy1[31:0];
        o.new_second_pos_x = x2[31:0];  o.new_second_pos_y = y2[31:0];
        o.new_second_vel_x = vx2[31:0]; o.new_second_vel_y = vy2[31:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. A strobe is sampled at the edge that ends its cycle;
    // reading right after the edge sees the value from before the edge.
    // ------------------------------------------------------------------------
    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want !== got && mismatch_count < 10)
            $display("mismatch %s: expected %0h, got %0h", name, want, got);
        return want === got;
    endfunction

    always @(posedge clk) begin
        t_pair_out want;
        bit        ok;
        if (rst_n && strobe) begin
            if (pending_responses.size() == 0) begin
                if (mismatch_count < 10)
                    $display("mismatch: result with no pair outstanding");
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                ok = 1'b1;
                ok &= field_ok("contact", 32'(want.contact), 32'(result.contact));
                ok &= field_ok("resolved", 32'(want.resolved), 32'(result.resolved));
                ok &= field_ok("first_pos_x", want.new_first_pos_x, result.new_first_pos_x);
                ok &= field_ok("first_pos_y", want.new_first_pos_y, result.new_first_pos_y);
                ok &= field_ok("first_vel_x", want.new_first_vel_x, result.new_first_vel_x);
                ok &= field_ok("first_vel_y", want.new_first_vel_y, result.new_first_vel_y);
                ok &= field_ok("second_pos_x", want.new_second_pos_x,
                               result.new_second_pos_x);
                ok &= field_ok("second_pos_y", want.new_second_pos_y,
                               result.new_second_pos_y);
                ok &= field_ok("second_vel_x", want.new_second_vel_x,
                               result.new_second_vel_x);
                ok &= field_ok("second_vel_y", want.new_second_vel_y,
                               result.new_second_vel_y);
                if (!ok) mismatch_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // One pair transfer. Start is left high so back-to-back pairs never see
    // a low pulse; each following cycle idles with a chance of gap_percent.
    task automatic send_pair(input t_pair_in p);
        pair <= p;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        pending_responses.push_back(resolve_pair(p, restitution_now));
        if ($urandom_range(99) < gap_percent) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_percent) @(posedge clk);
        end
    endtask

    // Wait until every result is back, then let the pipeline empty.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_restitution(input logic [CFG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        restitution_now = v;
    endtask

    function automatic t_pair_in noise_pair;
        t_pair_in     p;
        logic [383:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(t_pair_in)-1:0];
        return p;
    endfunction

    // A well-formed candidate: two circles near each other at a random scale,
    // usually overlapping, with velocities drawn at random.
    function automatic t_pair_in near_pair;
        t_pair_in p;
        int       scale;
        int       sh;
        longint   r1, r2;
        scale = $urandom_range(24, 8);
        sh = $urandom_range(9, 0);
        p = noise_pair();
        if ($urandom_range(9) == 0) begin
            p.first_pos_x = {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom)};
            p.first_pos_y = {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom)};
        end else begin
            p.first_pos_x = $signed($urandom) >>> sh;
            p.first_pos_y = $signed($urandom) >>> sh;
        end
        r1 = longint'($urandom) >> (32 - scale);
        r2 = longint'($urandom) >> (32 - scale);
        p.first_radius = r1[30:0];
        p.second_radius = r2[30:0];
        p.second_pos_x = p.first_pos_x + ($signed($urandom) >>> (32 - scale));
        p.second_pos_y = p.first_pos_y + ($signed($urandom) >>> (32 - scale));
        p.first_vel_x = $signed($urandom) >>> $urandom_range(16, 0);
        p.first_vel_y = $signed($urandom) >>> $urandom_range(16, 0);
        p.second_vel_x = $signed($urandom) >>> $urandom_range(16, 0);
        p.second_vel_y = $signed($urandom) >>> $urandom_range(16, 0);
        p.first_mass = 31'($urandom) >> $urandom_range(30, 0);
        p.second_mass = 31'($urandom) >> $urandom_range(30, 0);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    task automatic test_directed_cases;
        t_pair_in p;
        t_pair_in head_on;
        // Head-on pair: first at +1, second at -1, radius 1.5 each, closing.
        head_on = '0;
        head_on.first_pos_x = 32'sh0001_0000;
        head_on.second_pos_x = -32'sh0001_0000;
        head_on.first_radius = 31'h0001_8000;
        head_on.second_radius = 31'h0001_8000;
        head_on.first_vel_x = -32'sh0002_0000;
        head_on.second_vel_x = 32'sh0003_0000;
        head_on.first_mass = 31'h0001_0000;
        head_on.second_mass = 31'h0003_0000;
        send_pair(head_on);
        // Separating pair: velocities swapped in sign.
        p = head_on;
        p.first_vel_x = 32'sh0002_0000;
        p.second_vel_x = -32'sh0003_0000;
        send_pair(p);
        // Zero normal speed: only the push applies.
        p = head_on;
        p.first_vel_x = 0;
        p.second_vel_x = 0;
        p.first_vel_y = 32'sh0005_0000;
        p.second_vel_y = -32'sh0001_0000;
        send_pair(p);
        // Coincident centres.
        p = head_on;
        p.second_pos_x = p.first_pos_x;
        send_pair(p);
        // Exactly touching: contact and impulse, but no overlap to push.
        p = head_on;
        p.first_radius = 31'h0001_0000;
        p.second_radius = 31'h0001_0000;
        send_pair(p);
        // Just apart: no contact.
        p.first_radius = 31'h0000_FFFF;
        send_pair(p);
        // Zero masses, treated as the smallest mass.
        p = head_on;
        p.first_mass = '0;
        p.second_mass = '0;
        send_pair(p);
        p.second_mass = 31'h7FFF_FFFF;
        send_pair(p);
        // Diagonal approach with both coordinates negative differences.
        p = head_on;
        p.first_pos_x = -32'sh0000_8000;
        p.first_pos_y = -32'sh0000_8000;
        p.second_pos_x = 32'sh0000_8000;
        p.second_pos_y = 32'sh0000_8000;
        p.first_vel_x = 32'sh0004_0000;
        p.first_vel_y = 32'sh0004_0000;
        send_pair(p);
        // Squared distance past 64 bits.
        p = head_on;
        p.first_pos_x = 32'sh7FFF_FFFF;
        p.first_pos_y = 32'sh7FFF_FFFF;
        p.second_pos_x = 32'sh8000_0000;
        p.second_pos_y = 32'sh8000_0000;
        p.first_radius = 31'h7FFF_FFFF;
        p.second_radius = 31'h7FFF_FFFF;
        send_pair(p);
        // Huge radii, extreme positions and velocities: saturating results.
        p.first_pos_y = 0;
        p.second_pos_y = 0;
        p.first_vel_x = 32'sh8000_0000;
        p.first_vel_y = 32'sh7FFF_FFFF;
        p.second_vel_x = 32'sh7FFF_FFFF;
        p.second_vel_y = 32'sh8000_0000;
        send_pair(p);
        p.first_pos_x = 32'sh7FFF_0000;
        p.second_pos_x = 32'sh7FF0_0000;
        send_pair(p);
        // All zeros and all ones.
        send_pair('0);
        send_pair('1);
        drain();
    endtask

    task automatic test_random_pairs(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80) send_pair(near_pair());
            else send_pair(noise_pair());
        end
    endtask

    // Each restitution setting gets a slice of random pairs; the gap pattern
    // changes from sparse to heavy to none across the run.
    task automatic test_restitution_sweep;
        write_restitution(17'd0);
        test_directed_cases();
        test_random_pairs(200);
        write_restitution(17'd65536);
        test_random_pairs(200);
        write_restitution(17'h1FFFF);
        test_directed_cases();
        test_random_pairs(200);
        gap_percent = 85;
        write_restitution(17'($urandom_range(65536)));
        test_random_pairs(250);
        write_restitution(17'd1);
        test_random_pairs(150);
        gap_percent = 0;
        write_restitution(RESTITUTION_RESET);
        test_random_pairs(250);
        write_restitution(17'($urandom));
        test_random_pairs(200);
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        pair = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatch_count = 0;
        gap_percent = 7;
        restitution_now = RESTITUTION_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // The reset value of restitution is checked first.
        test_directed_cases();
        test_restitution_sweep();
        if (mismatch_count == 0) begin
            $display("tb_pair_collision_impulse_resolver_top: done, clean");
        end else begin
            $display("tb_pair_collision_impulse_resolver_top: done, errors");
        end
        $finish;
    end

    // Safety net well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("tb_pair_collision_impulse_resolver_top: done, errors");
        $finish;
    end

endmodule

@@ pair_collision_impulse_resolver_top.f @@
rtl/core/pcir_pkg.sv
rtl/core/pcir_sqrt.sv
rtl/core/pcir_div.sv
rtl/core/pair_collision_impulse_resolver_top.sv
tb/tb_pair_collision_impulse_resolver_top.sv
